// ===== hdl/assert_macros.svh =====
// assertion macros used by the connection table rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion that is disabled while reset is high
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that is also checked during reset
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/psct_pkg.sv =====
// package: sizes, operation codes and sequencer states of the connection table
`timescale 1ns / 1ps

package psct_pkg;

   // table geometry
   localparam int ENTRIES = 64;
   localparam int IDX_W   = $clog2(ENTRIES);

   // field widths
   localparam int OP_W    = 3;
   localparam int ADDR_W  = 32;
   localparam int COUNT_W = 16;
   localparam int TIME_W  = 48;
   localparam int HOLD_W  = 32;
   localparam int WORD_W  = ADDR_W + COUNT_W + TIME_W;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // operation codes
   localparam logic [OP_W-1:0] OP_REGISTER   = 3'd0;
   localparam logic [OP_W-1:0] OP_UNREGISTER = 3'd1;
   localparam logic [OP_W-1:0] OP_QRY_COUNT  = 3'd2;
   localparam logic [OP_W-1:0] OP_QRY_EXPIRE = 3'd3;
   localparam logic [OP_W-1:0] OP_CLEAR      = 3'd4;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EXEC
   } state_type;

   // one stored entry
   typedef struct packed {
      logic [ADDR_W-1:0]  addr;
      logic [COUNT_W-1:0] count;
      logic [TIME_W-1:0]  last;
   } entry_type;

endpackage

// ===== hdl/per_source_connection_table.sv =====
// top level: per-source connection table with a sequential key search
`timescale 1ns / 1ps

// Connection table of psct_pkg::ENTRIES slots keyed by IPv4 source address. Each
// request word is searched for by walking the entry memory one slot per cycle through
// its single read port, lowest slot first, stopping at the first match; the lowest
// free slot is noted on the way. The update and the response register are written in
// the exec state after the search, once the response register is free. One request
// is worked on at a time; the next request is taken once the previous one has been
// handed to the response register. The user must write hold_ms through the csr port
// only while the block is idle; the block itself does not enforce this.

`include "assert_macros.svh"

module per_source_connection_table (
   input  logic                            clock,
   input  logic                            reset,
   // configuration
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [psct_pkg::HOLD_W-1:0]     csr_hold_ms,
   // request channel
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [psct_pkg::OP_W-1:0]       req_op,
   input  logic [psct_pkg::ADDR_W-1:0]     req_src_addr,
   input  logic [psct_pkg::TIME_W-1:0]     req_now_ms,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_found,
   output logic [psct_pkg::COUNT_W-1:0]    rsp_conn_count,
   output logic                            rsp_expired,
   output logic                            rsp_table_full,
   output logic                            rsp_removed
);

   // configuration register
   logic [psct_pkg::HOLD_W-1:0] hold_ff;

   // latched request
   logic [psct_pkg::OP_W-1:0]   op_ff;
   logic [psct_pkg::ADDR_W-1:0] key_ff;
   logic [psct_pkg::TIME_W-1:0] now_ff;

   // sequencer and search state
   psct_pkg::state_type         state_ff, state_in;
   logic [psct_pkg::IDX_W-1:0]  idx_ff, idx_in;
   logic                        last_issued_ff;
   logic                        pend_ff;
   logic [psct_pkg::IDX_W-1:0]  cmp_idx_ff;
   logic                        cmp_valid_ff;
   logic [psct_pkg::IDX_W-1:0]  slot_ff;
   logic                        hit_ff;
   logic [psct_pkg::IDX_W-1:0]  free_ff;
   logic                        free_found_ff;

   // storage
   logic [psct_pkg::ENTRIES-1:0] valid_ff;
   psct_pkg::entry_type          entry_mem [psct_pkg::ENTRIES];
   psct_pkg::entry_type          rd_data_ff;

   // response registers
   logic                         rsp_valid_ff;
   logic                         found_ff;
   logic [psct_pkg::COUNT_W-1:0] count_ff;
   logic                         expired_ff;
   logic                         full_ff;
   logic                         removed_ff;

   // control
   logic req_acc;
   logic rd_en;
   logic hit;
   logic miss;
   logic exec_go;

   // update results
   logic                         wr_en;
   logic [psct_pkg::IDX_W-1:0]   wr_idx;
   psct_pkg::entry_type          wr_data;
   logic                         set_valid;
   logic                         clr_valid;
   logic                         clr_all;
   logic                         found_in;
   logic [psct_pkg::COUNT_W-1:0] count_in;
   logic                         expired_in;
   logic                         full_in;
   logic                         removed_in;
   logic [psct_pkg::COUNT_W-1:0] dec_count;
   logic                         old_expired;
   logic [psct_pkg::TIME_W:0]    deadline;

   assign csr_ready = 1'b1;
   assign req_acc   = req_valid && req_ready;

   // compare stage of the search
   assign hit  = (state_ff == psct_pkg::ST_SCAN) && pend_ff && cmp_valid_ff &&
                 (rd_data_ff.addr == key_ff);
   assign miss = (state_ff == psct_pkg::ST_SCAN) && pend_ff && last_issued_ff && !hit;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         psct_pkg::ST_IDLE: begin
            if (req_acc) state_in = psct_pkg::ST_SCAN;
         end
         psct_pkg::ST_SCAN: begin
            if (hit || miss) state_in = psct_pkg::ST_EXEC;
         end
         psct_pkg::ST_EXEC: begin
            if (exec_go) state_in = psct_pkg::ST_IDLE;
         end
         default: state_in = psct_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      rd_en     = 1'b0;
      exec_go   = 1'b0;
      unique case (state_ff)
         psct_pkg::ST_IDLE: req_ready = 1'b1;
         psct_pkg::ST_SCAN: rd_en     = !last_issued_ff && !hit;
         psct_pkg::ST_EXEC: exec_go   = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   // scan index
   always_comb begin
      idx_in = idx_ff;
      if (req_acc)    idx_in = '0;
      else if (rd_en) idx_in = idx_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= psct_pkg::ST_IDLE;
         idx_ff         <= '0;
         last_issued_ff <= 1'b0;
         pend_ff        <= 1'b0;
         hit_ff         <= 1'b0;
         free_found_ff  <= 1'b0;
         hold_ff        <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         pend_ff  <= rd_en;
         if (csr_valid && csr_ready) hold_ff <= csr_hold_ms;
         if (req_acc) begin
            last_issued_ff <= 1'b0;
            hit_ff         <= 1'b0;
            free_found_ff  <= 1'b0;
         end else begin
            if (rd_en && idx_ff == psct_pkg::IDX_W'(psct_pkg::ENTRIES - 1))
               last_issued_ff <= 1'b1;
            if (hit) hit_ff <= 1'b1;
            if (rd_en && !valid_ff[idx_ff] && !free_found_ff) free_found_ff <= 1'b1;
         end
      end
   end

   // request latch and search bookkeeping
   always_ff @(posedge clock) begin
      if (req_acc) begin
         op_ff  <= req_op;
         key_ff <= req_src_addr;
         now_ff <= req_now_ms;
      end
      if (rd_en) begin
         cmp_idx_ff   <= idx_ff;
         cmp_valid_ff <= valid_ff[idx_ff];
         if (!valid_ff[idx_ff] && !free_found_ff) free_ff <= idx_ff;
      end
      if (hit) slot_ff <= cmp_idx_ff;
   end

   // entry memory: one read port for the search, one write port for the update
   always_ff @(posedge clock) begin
      if (rd_en) rd_data_ff <= entry_mem[idx_ff];
      if (wr_en) entry_mem[wr_idx] <= wr_data;
   end

   // expiry of the stored time, 49-bit sum so no wrap
   assign deadline    = {1'b0, rd_data_ff.last} +
                        {{(psct_pkg::TIME_W + 1 - psct_pkg::HOLD_W){1'b0}}, hold_ff};
   assign old_expired = deadline < {1'b0, now_ff};
   assign dec_count   = (rd_data_ff.count == '0) ? '0 : rd_data_ff.count - 1'b1;

   // operation decode and update
   always_comb begin
      wr_en      = 1'b0;
      wr_idx     = slot_ff;
      wr_data    = rd_data_ff;
      set_valid  = 1'b0;
      clr_valid  = 1'b0;
      clr_all    = 1'b0;
      found_in   = hit_ff;
      count_in   = '0;
      expired_in = 1'b1;
      full_in    = 1'b0;
      removed_in = 1'b0;
      unique case (op_ff)
         psct_pkg::OP_REGISTER: begin
            expired_in   = !hit_ff && !free_found_ff;
            wr_data.last = now_ff;
            if (hit_ff) begin
               wr_en         = 1'b1;
               wr_data.count = (rd_data_ff.count == psct_pkg::COUNT_MAX) ?
                               rd_data_ff.count : rd_data_ff.count + 1'b1;
               count_in      = wr_data.count;
            end else if (free_found_ff) begin
               wr_en         = 1'b1;
               wr_idx        = free_ff;
               set_valid     = 1'b1;
               wr_data.addr  = key_ff;
               wr_data.count = psct_pkg::COUNT_W'(1);
               count_in      = psct_pkg::COUNT_W'(1);
            end else begin
               full_in = 1'b1;
            end
         end
         psct_pkg::OP_UNREGISTER: begin
            if (hit_ff) begin
               if (dec_count == '0 && old_expired) begin
                  clr_valid  = 1'b1;
                  removed_in = 1'b1;
               end else begin
                  wr_en         = 1'b1;
                  wr_data.count = dec_count;
                  count_in      = dec_count;
                  expired_in    = old_expired;
               end
            end
         end
         psct_pkg::OP_CLEAR: begin
            clr_all = 1'b1;
         end
         default: begin
            // both queries and the unused codes only report
            if (hit_ff) begin
               count_in   = rd_data_ff.count;
               expired_in = old_expired;
            end
         end
      endcase
      if (!exec_go) begin
         wr_en     = 1'b0;
         set_valid = 1'b0;
         clr_valid = 1'b0;
         clr_all   = 1'b0;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (clr_all) begin
         valid_ff <= '0;
      end else begin
         if (set_valid) valid_ff[free_ff] <= 1'b1;
         if (clr_valid) valid_ff[slot_ff] <= 1'b0;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (exec_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_go) begin
         found_ff   <= found_in;
         count_ff   <= count_in;
         expired_ff <= expired_in;
         full_ff    <= full_in;
         removed_ff <= removed_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = found_ff;
   assign rsp_conn_count = count_ff;
   assign rsp_expired    = expired_ff;
   assign rsp_table_full = full_ff;
   assign rsp_removed    = removed_ff;

   // checks
   `ASSERT_CLK(a_full_is_miss, clock, reset, rsp_valid_ff && full_ff |-> !found_ff && count_ff == '0 && expired_ff, "table full reported with a hit")
   `ASSERT_CLK(a_removed_was_found, clock, reset, rsp_valid_ff && removed_ff |-> found_ff && count_ff == '0 && expired_ff, "removal without a hit")
   `ASSERT_CLK(a_accept_starts_scan, clock, reset, req_acc |=> state_ff == psct_pkg::ST_SCAN, "accepted word did not start a search")
   `ASSERT_CLK(a_hit_not_miss, clock, reset, !(hit && miss), "search reported hit and miss together")

endmodule
